FILE: design/assert_macros.svh
// Assertion macros used by the scheduler decide sequencer (lbss_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LBSS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lbss assertion failed");
`define LBSS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) \
    else $error("lbss assertion failed");
`else
`define LBSS_ASSERT(lbl, clk, rst, prop)
`define LBSS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

FILE: design/lbss_pkg.sv
// Types and constants of the layered buffer segment scheduler.
package lbss_pkg;

  localparam logic [1:0] OP_REPORT  = 2'd0;
  localparam logic [1:0] OP_CONSUME = 2'd1;
  localparam logic [1:0] OP_DECIDE  = 2'd2;

  localparam logic [1:0] PH_STEADY = 2'd0;
  localparam logic [1:0] PH_GROW   = 2'd1;
  localparam logic [1:0] PH_UP     = 2'd2;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAMMA_MIN     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA_STEP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEGMENT_COUNT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PHASE     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_INIT,
    S_SCAN,
    S_UP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  layer;
    logic [7:0]  fill_count;
    logic [15:0] seg_num;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  chosen_layer;
    logic [15:0] next_segment;
    logic [1:0]  phase;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  max_level;
    logic [3:0]  gamma_min;
    logic [3:0]  alpha_step;
    logic [15:0] segment_count;
    logic [1:0]  max_phase;
  } cfg_t;

  typedef struct packed {
    logic        fill_nz;
    logic [7:0]  fill;
    logic        cand_ok;
    logic [15:0] next_segment;
  } rd_t;

endpackage

FILE: design/lbss_table.sv
// Per-layer buffer table, last consumed segment and candidate segment logic.
module lbss_table #(
  parameter int NUM_LAYERS = 8,
  parameter int SEG_NUM_BITS = 16,
  parameter int LW = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  lbss_pkg::in_item_t  wr_item,
  input  lbss_pkg::cfg_t      cfg,
  input  logic [LW-1:0]       idx,
  output lbss_pkg::rd_t       rd
);

  localparam int CW = SEG_NUM_BITS + 2;

  logic [7:0]              layer_fill [NUM_LAYERS];
  logic [SEG_NUM_BITS-1:0] layer_last_segment [NUM_LAYERS];
  logic [SEG_NUM_BITS:0]   last_consumed;

  logic [31:0]             seg_ext;
  logic [SEG_NUM_BITS-1:0] seg_masked;
  logic                    layer_ok;
  logic                    do_report;
  logic                    do_consume;
  logic [LW-1:0]           wr_idx;
  logic [CW-1:0]           lc_ext;
  logic [CW-1:0]           cand;
  logic [7:0]              fill_rd;

  assign seg_ext    = 32'(wr_item.seg_num);
  assign seg_masked = seg_ext[SEG_NUM_BITS-1:0];
  assign layer_ok   = 5'(wr_item.layer) < 5'(NUM_LAYERS);
  assign wr_idx     = LW'(wr_item.layer);
  assign do_report  = wr_en && (wr_item.operation == lbss_pkg::OP_REPORT) && layer_ok;
  assign do_consume = wr_en && (wr_item.operation == lbss_pkg::OP_CONSUME);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LAYERS; i++) begin
        layer_fill[i] <= '0;
      end
      last_consumed <= '1;
    end else begin
      if (do_report) begin
        layer_fill[wr_idx] <= wr_item.fill_count;
      end
      if (do_consume) begin
        last_consumed <= {1'b0, seg_masked};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_report) begin
      layer_last_segment[wr_idx] <= seg_masked;
    end
  end

  assign fill_rd = layer_fill[idx];
  assign lc_ext  = {last_consumed[SEG_NUM_BITS], last_consumed};

  always_comb begin
    if (fill_rd != 8'd0) begin
      cand = {2'b00, layer_last_segment[idx]} + CW'(1);
    end else if (idx == '0) begin
      cand = lc_ext + CW'(1);
    end else begin
      cand = lc_ext + CW'(cfg.gamma_min);
    end
  end

  assign rd.fill_nz      = fill_rd != 8'd0;
  assign rd.fill         = fill_rd;
  assign rd.cand_ok      = !cand[CW-1] && (34'(cand) < 34'(cfg.segment_count));
  assign rd.next_segment = 16'(cand);

endmodule

FILE: design/lbss_ctrl.sv
// Decide sequencer: top search, steady and growing passes, upswitch, result register.
`include "assert_macros.svh"

module lbss_ctrl #(
  parameter int NUM_LAYERS = 8,
  parameter int LW = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lbss_pkg::cfg_t      cfg,
  input  lbss_pkg::rd_t       rd,
  output logic [LW-1:0]       idx,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output lbss_pkg::out_item_t out_data
);

  localparam int TB = $clog2((NUM_LAYERS + 2) * 15 + 1);
  localparam int CMPW = (TB > 8) ? TB : 8;

  lbss_pkg::state_t    state, state_next;
  logic [LW-1:0]       idx_next;
  logic [LW-1:0]       top, top_next;
  logic                pass, pass_next;
  logic [CMPW-1:0]     target, target_next;
  lbss_pkg::out_item_t res, res_next;
  logic                out_valid_next;
  logic                load;

  logic [LW-1:0]       lim;
  logic [LW:0]         span;
  logic [LW+4:0]       prod;
  logic                needy;

  always_comb begin
    if (5'(cfg.max_level) > 5'(NUM_LAYERS - 1)) begin
      lim = LW'(NUM_LAYERS - 1);
    end else begin
      lim = LW'(cfg.max_level);
    end
  end

  assign span  = {1'b0, top} + (pass ? (LW+1)'(2) : (LW+1)'(0));
  assign prod  = (LW+5)'(span) * (LW+5)'(cfg.alpha_step);
  assign needy = CMPW'(rd.fill) < target;
  assign load  = (state == lbss_pkg::S_DONE) && (!out_valid || !out_stall);
  assign busy  = state != lbss_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lbss_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    top    <= top_next;
    pass   <= pass_next;
    target <= target_next;
    res    <= res_next;
    if (load) begin
      out_data <= res;
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    top_next       = top;
    pass_next      = pass;
    target_next    = target;
    res_next       = res;
    out_valid_next = load || (out_valid && out_stall);
    unique case (state)
      lbss_pkg::S_IDLE: begin
        if (start) begin
          idx_next   = lim;
          state_next = lbss_pkg::S_TOP;
        end
      end
      lbss_pkg::S_TOP: begin
        if (rd.fill_nz || idx == '0) begin
          top_next   = idx;
          idx_next   = '0;
          pass_next  = 1'b0;
          state_next = lbss_pkg::S_INIT;
        end else begin
          idx_next = LW'(idx - 1'b1);
        end
      end
      lbss_pkg::S_INIT: begin
        target_next = CMPW'(prod) + CMPW'(cfg.gamma_min);
        state_next  = lbss_pkg::S_SCAN;
      end
      lbss_pkg::S_SCAN: begin
        if (needy && rd.cand_ok) begin
          res_next.found        = 1'b1;
          res_next.chosen_layer = 3'(idx);
          res_next.next_segment = rd.next_segment;
          res_next.phase        = pass ? lbss_pkg::PH_GROW : lbss_pkg::PH_STEADY;
          state_next            = lbss_pkg::S_DONE;
        end else if (idx == top) begin
          res_next = '0;
          if (!pass && cfg.max_phase >= lbss_pkg::PH_GROW) begin
            pass_next  = 1'b1;
            idx_next   = '0;
            state_next = lbss_pkg::S_INIT;
          end else if (pass && cfg.max_phase >= lbss_pkg::PH_UP && top < lim) begin
            idx_next   = LW'(top + 1'b1);
            state_next = lbss_pkg::S_UP;
          end else begin
            state_next = lbss_pkg::S_DONE;
          end
        end else begin
          idx_next    = LW'(idx + 1'b1);
          target_next = target - CMPW'(cfg.alpha_step);
        end
      end
      lbss_pkg::S_UP: begin
        res_next = '0;
        if (rd.cand_ok) begin
          res_next.found        = 1'b1;
          res_next.chosen_layer = 3'(idx);
          res_next.next_segment = rd.next_segment;
          res_next.phase        = lbss_pkg::PH_UP;
        end
        state_next = lbss_pkg::S_DONE;
      end
      lbss_pkg::S_DONE: begin
        if (load) begin
          state_next = lbss_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lbss_pkg::S_IDLE;
      end
    endcase
  end

  `LBSS_ASSERT(a_out_from_done, clk, rst, $rose(out_valid) |-> $past(state) == lbss_pkg::S_DONE)
  `LBSS_ASSERT(a_idle_zero, clk, rst, (out_valid && !out_data.found) |-> (out_data.chosen_layer == 3'd0 && out_data.next_segment == 16'd0 && out_data.phase == lbss_pkg::PH_STEADY))
  `LBSS_ASSERT(a_scan_range, clk, rst, (state == lbss_pkg::S_SCAN) |-> idx <= top)
  `LBSS_ASSERT_NEXT(a_up_done, clk, rst, state == lbss_pkg::S_UP, state == lbss_pkg::S_DONE)

endmodule

FILE: design/layered_buffer_segment_scheduler_unit.sv
// Layered buffer segment scheduler: top level with registers and handshakes.
// Report and consume items: accepted while idle, no result.
// Decide item: the result is built by the one-layer-per-cycle scan (top search, steady pass,
// growing pass, upswitch) and goes out through the output register with out_valid.
// One item at a time; the next item is taken while the result waits in the output register.
// rst (sync, active high) empties all layers, clears last consumed to -1, loads register defaults.
module layered_buffer_segment_scheduler_unit #(
  parameter int NUM_LAYERS = 8,
  parameter int SEG_NUM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lbss_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lbss_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  logic [lbss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lbss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int LW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

  lbss_pkg::cfg_t cfg;
  lbss_pkg::rd_t  rd;
  logic [LW-1:0]  idx;
  logic           busy;
  logic           in_accept;
  logic           start;

  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign start     = in_accept && (in_data.operation == lbss_pkg::OP_DECIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_level     <= 3'd7;
      cfg.gamma_min     <= 4'd3;
      cfg.alpha_step    <= 4'd3;
      cfg.segment_count <= 16'd65535;
      cfg.max_phase     <= lbss_pkg::PH_UP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lbss_pkg::REG_MAX_LEVEL:     cfg.max_level     <= cfg_data[2:0];
        lbss_pkg::REG_GAMMA_MIN:     cfg.gamma_min     <= cfg_data[3:0];
        lbss_pkg::REG_ALPHA_STEP:    cfg.alpha_step    <= cfg_data[3:0];
        lbss_pkg::REG_SEGMENT_COUNT: cfg.segment_count <= cfg_data;
        lbss_pkg::REG_MAX_PHASE:     cfg.max_phase     <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  lbss_table #(
    .NUM_LAYERS   (NUM_LAYERS),
    .SEG_NUM_BITS (SEG_NUM_BITS),
    .LW           (LW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_accept),
    .wr_item (in_data),
    .cfg     (cfg),
    .idx     (idx),
    .rd      (rd)
  );

  lbss_ctrl #(
    .NUM_LAYERS (NUM_LAYERS),
    .LW         (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg       (cfg),
    .rd        (rd),
    .idx       (idx),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: dv/layered_buffer_segment_scheduler_unit_tb.sv
// Self-checking testbench for the layered buffer segment scheduler unit.
module layered_buffer_segment_scheduler_unit_tb;

  localparam int NUM_LAYERS = 8;
  localparam int SEG_NUM_BITS = 16;
  localparam int SETTLE_CYCLES = 3 * NUM_LAYERS + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_SEGMENTS = 8;
  localparam int RANDOM_PER_SEGMENT = 210;
  localparam int MAX_PRINTED = 50;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] PH_ALIAS = 2'd3;

  typedef logic [lbss_pkg::CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [lbss_pkg::CFG_DATA_BITS-1:0] cfg_data_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  lbss_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  lbss_pkg::out_item_t out_data;
  logic cfg_write;
  cfg_idx_t cfg_index;
  cfg_data_t cfg_data;

  lbss_pkg::cfg_t sched_cfg;
  logic [7:0] sched_fill [NUM_LAYERS];
  logic [SEG_NUM_BITS-1:0] sched_last_seg [NUM_LAYERS];
  int sched_consumed;
  lbss_pkg::out_item_t decisions_q [$];

  idle_mode_e idle_mode = IDLE_NONE;
  int hold_left = 0;
  int quiet_cycles = 0;
  int error_count = 0;
  int items_sent = 0;
  int settings_done = 0;
  int idle_seen = 0;
  int phase_seen [3] = '{0, 0, 0};
  logic [15:0] play_seg = 16'd0;

  layered_buffer_segment_scheduler_unit #(
    .NUM_LAYERS(NUM_LAYERS),
    .SEG_NUM_BITS(SEG_NUM_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic sched_reset();
    sched_cfg.max_level = 3'd7;
    sched_cfg.gamma_min = 4'd3;
    sched_cfg.alpha_step = 4'd3;
    sched_cfg.segment_count = 16'hFFFF;
    sched_cfg.max_phase = lbss_pkg::PH_UP;
    for (int i = 0; i < NUM_LAYERS; i++) begin
      sched_fill[i] = '0;
      sched_last_seg[i] = '0;
    end
    sched_consumed = -1;
  endtask

  function automatic void apply_reg(input cfg_idx_t idx, input cfg_data_t data);
    case (idx)
      lbss_pkg::REG_MAX_LEVEL: sched_cfg.max_level = data[2:0];
      lbss_pkg::REG_GAMMA_MIN: sched_cfg.gamma_min = data[3:0];
      lbss_pkg::REG_ALPHA_STEP: sched_cfg.alpha_step = data[3:0];
      lbss_pkg::REG_SEGMENT_COUNT: sched_cfg.segment_count = data[15:0];
      lbss_pkg::REG_MAX_PHASE: sched_cfg.max_phase = data[1:0];
      default: ;
    endcase
  endfunction

  function automatic int seg_candidate(input int lay);
    if (sched_fill[lay] != 0) return int'(sched_last_seg[lay]) + 1;
    if (lay == 0) return sched_consumed + 1;
    return sched_consumed + int'(sched_cfg.gamma_min);
  endfunction

  function automatic bit seg_ok(input int c);
    return c >= 0 && c < int'(sched_cfg.segment_count);
  endfunction

  function automatic lbss_pkg::out_item_t scan_pass(input int top, input int extra,
                                                    input logic [1:0] ph);
    lbss_pkg::out_item_t r;
    int target;
    int c;
    r = '0;
    for (int i = 0; i <= top; i++) begin
      target = int'(sched_cfg.gamma_min) + (top + extra - i) * int'(sched_cfg.alpha_step);
      if (int'(sched_fill[i]) < target) begin
        c = seg_candidate(i);
        if (seg_ok(c)) begin
          r.found = 1'b1;
          r.chosen_layer = 3'(i);
          r.next_segment = c[15:0];
          r.phase = ph;
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic lbss_pkg::out_item_t predict_decision();
    lbss_pkg::out_item_t r;
    int lim;
    int top;
    int c;
    lim = int'(sched_cfg.max_level);
    if (lim > NUM_LAYERS - 1) lim = NUM_LAYERS - 1;
    top = lim;
    while (top > 0 && sched_fill[top] == 0) top--;
    r = scan_pass(top, 0, lbss_pkg::PH_STEADY);
    if (r.found || sched_cfg.max_phase < lbss_pkg::PH_GROW) return r;
    r = scan_pass(top, 2, lbss_pkg::PH_GROW);
    if (r.found || sched_cfg.max_phase < lbss_pkg::PH_UP) return r;
    if (top + 1 <= lim) begin
      c = seg_candidate(top + 1);
      if (seg_ok(c)) begin
        r.found = 1'b1;
        r.chosen_layer = 3'(top + 1);
        r.next_segment = c[15:0];
        r.phase = lbss_pkg::PH_UP;
      end
    end
    return r;
  endfunction

  function automatic void absorb_item(input lbss_pkg::in_item_t it);
    case (it.operation)
      lbss_pkg::OP_REPORT: begin
        if (int'(it.layer) < NUM_LAYERS) begin
          sched_fill[it.layer] = it.fill_count;
          sched_last_seg[it.layer] = it.seg_num;
        end
      end
      lbss_pkg::OP_CONSUME: sched_consumed = int'(it.seg_num);
      lbss_pkg::OP_DECIDE: decisions_q = {decisions_q, predict_decision()};
      default: ;
    endcase
  endfunction

  function automatic int send_pct();
    case (idle_mode)
      IDLE_SENDER: return 74;
      IDLE_BOTH: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 74;
      IDLE_BOTH: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic lbss_pkg::in_item_t make_item(input logic [1:0] op, input logic [2:0] lay,
                                                   input logic [7:0] fc, input logic [15:0] sn);
    lbss_pkg::in_item_t it;
    it.operation = op;
    it.layer = lay;
    it.fill_count = fc;
    it.seg_num = sn;
    return it;
  endfunction

  function automatic lbss_pkg::in_item_t random_item();
    lbss_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.operation = 2'($urandom);
    it.layer = 3'($urandom);
    it.fill_count = 8'($urandom);
    it.seg_num = 16'($urandom);
    if (pick < 6) return it;
    if (pick < 46) begin
      it.operation = lbss_pkg::OP_DECIDE;
    end else if (pick < 80) begin
      it.operation = lbss_pkg::OP_REPORT;
      case ($urandom_range(9))
        0, 1, 2: it.fill_count = 8'd0;
        8, 9: it.fill_count = 8'($urandom);
        default: it.fill_count = 8'($urandom_range(24));
      endcase
      if ($urandom_range(3) != 0) it.seg_num = play_seg + 16'($urandom_range(24));
    end else begin
      it.operation = lbss_pkg::OP_CONSUME;
      if ($urandom_range(9) == 0) play_seg = it.seg_num;
      else play_seg = play_seg + 16'($urandom_range(3));
      it.seg_num = play_seg;
    end
    return it;
  endfunction

  task automatic send_item(input lbss_pkg::in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_pct()) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    absorb_item(it);
    items_sent++;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (decisions_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic set_config(input logic [2:0] lvl, input logic [3:0] gam, input logic [3:0] alp,
                            input logic [15:0] cnt, input logic [1:0] mph);
    logic [15:0] noise;
    noise = 16'($urandom);
    write_reg(lbss_pkg::REG_MAX_LEVEL, {noise[15:3], lvl});
    write_reg(lbss_pkg::REG_GAMMA_MIN, {noise[15:4], gam});
    write_reg(lbss_pkg::REG_ALPHA_STEP, {noise[15:4], alp});
    write_reg(lbss_pkg::REG_SEGMENT_COUNT, cnt);
    write_reg(lbss_pkg::REG_MAX_PHASE, {noise[15:2], mph});
    write_reg(cfg_idx_t'($urandom_range(int'(lbss_pkg::REG_MAX_PHASE) + 1,
                                        (1 << lbss_pkg::CFG_IDX_BITS) - 1)),
              16'($urandom));
    cfg_write <= 1'b0;
    settings_done++;
  endtask

  task automatic set_random_config();
    logic [15:0] cnt;
    case ($urandom_range(2))
      0: cnt = 16'hFFFF;
      1: cnt = 16'($urandom);
      default: cnt = play_seg + 16'($urandom_range(40));
    endcase
    set_config(3'($urandom), 4'($urandom), 4'($urandom), cnt, 2'($urandom));
  endtask

  task automatic test_empty_start();
    idle_mode = IDLE_NONE;
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
    send_item(make_item(OP_UNUSED, 3'd7, 8'hFF, 16'hFFFF));
  endtask

  task automatic test_reports_and_consumes();
    send_item(make_item(lbss_pkg::OP_REPORT, 3'd0, 8'hFF, 16'hFFFF));
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
    send_item(make_item(lbss_pkg::OP_CONSUME, 3'd5, 8'hA5, 16'hFFFF));
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd7, 8'hFF, 16'hFFFF));
    send_item(make_item(lbss_pkg::OP_REPORT, 3'd7, 8'd1, 16'd0));
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd2, 8'h5A, 16'h5A5A));
  endtask

  task automatic test_pass_gating();
    settle_block();
    set_config(3'd7, 4'd2, 4'd1, 16'hFFFF, lbss_pkg::PH_STEADY);
    send_item(make_item(lbss_pkg::OP_REPORT, 3'd7, 8'd0, 16'd0));
    send_item(make_item(lbss_pkg::OP_REPORT, 3'd0, 8'd2, 16'd10));
    send_item(make_item(lbss_pkg::OP_CONSUME, 3'd0, 8'd0, 16'd0));
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
    settle_block();
    set_config(3'd7, 4'd2, 4'd1, 16'hFFFF, lbss_pkg::PH_GROW);
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
    settle_block();
    set_config(3'd7, 4'd2, 4'd1, 16'hFFFF, PH_ALIAS);
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
    send_item(make_item(lbss_pkg::OP_REPORT, 3'd0, 8'd200, 16'd10));
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
    settle_block();
    set_config(3'd0, 4'd2, 4'd1, 16'hFFFF, lbss_pkg::PH_UP);
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
  endtask

  task automatic test_segment_bounds();
    settle_block();
    set_config(3'd7, 4'd15, 4'd15, 16'd0, lbss_pkg::PH_UP);
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
    settle_block();
    set_config(3'd7, 4'd15, 4'd15, 16'd12, lbss_pkg::PH_UP);
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
    settle_block();
    set_config(3'd7, 4'd15, 4'd15, 16'd16, lbss_pkg::PH_UP);
    send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
  endtask

  task automatic test_output_hold();
    idle_mode = IDLE_NONE;
    hold_left = HOLD_CYCLES;
    for (int k = 0; k < 12; k++) send_item(random_item());
    for (int k = 0; k < 6; k++) send_item(make_item(lbss_pkg::OP_DECIDE, 3'd0, 8'd0, 16'd0));
  endtask

  task automatic test_random_traffic();
    lbss_pkg::in_item_t it;
    int n;
    for (int s = 0; s < RANDOM_SEGMENTS; s++) begin
      settle_block();
      case (s)
        0: set_config(3'd7, 4'd15, 4'd15, 16'hFFFF, PH_ALIAS);
        1: set_config(3'd0, 4'd0, 4'd0, 16'hFFFF, lbss_pkg::PH_STEADY);
        default: set_random_config();
      endcase
      idle_mode = idle_mode_e'(s % 4);
      n = 0;
      while (n < RANDOM_PER_SEGMENT) begin
        it = random_item();
        send_item(it);
        if (it.operation != OP_UNUSED) n++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct());
    end
  end

  always @(posedge clk) begin
    lbss_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (decisions_q.size() == 0) begin
        note_mismatch("result with no decision pending");
      end else begin
        want = decisions_q.pop_front();
        if (out_data.found !== want.found)
          note_mismatch($sformatf("found %0b, want %0b", out_data.found, want.found));
        if (out_data.chosen_layer !== want.chosen_layer)
          note_mismatch($sformatf("chosen_layer %0d, want %0d",
                                  out_data.chosen_layer, want.chosen_layer));
        if (out_data.next_segment !== want.next_segment)
          note_mismatch($sformatf("next_segment %0d, want %0d",
                                  out_data.next_segment, want.next_segment));
        if (out_data.phase !== want.phase)
          note_mismatch($sformatf("phase %0d, want %0d", out_data.phase, want.phase));
        if (!want.found) idle_seen++;
        else if (int'(want.phase) < 3) phase_seen[want.phase]++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no progress for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    sched_reset();
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_start();
    test_reports_and_consumes();
    test_pass_gating();
    test_segment_bounds();
    test_output_hold();
    test_random_traffic();
    settle_block();
    if (decisions_q.size() != 0)
      note_mismatch($sformatf("%0d decisions never answered", decisions_q.size()));
    $display("Run: %0d items over %0d register settings, %0d mismatches.",
             items_sent, settings_done, error_count);
    $display("Decisions: steady %0d, growing %0d, upswitching %0d, idle %0d.",
             phase_seen[0], phase_seen[1], phase_seen[2], idle_seen);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
